@@ src/xrfpd_pkg.sv @@
// Package for the X10 RF pulse-distance decoder: widths, config and result types,
// register indices and the byte bit-reversal helper.
// No dependencies.
`timescale 1ns / 1ps

package xrfpd_pkg;

    localparam int INTERVAL_W      = 16;
    localparam int CFG_DATA_W      = 16;
    localparam int CFG_INDEX_W     = 3;
    localparam int BUF_W           = 32;
    localparam int IDX_W           = $clog2(BUF_W);
    localparam int POS_W           = 6;
    localparam int BYTE_W          = 8;
    localparam int OUT_DATA_W      = 4 * BYTE_W;
    localparam int FRAME_BITS_DEF  = 32;

    localparam logic [BYTE_W-1:0] SEC_LOW_XOR  = 8'h0F;
    localparam logic [BYTE_W-1:0] SEC_HIGH_XOR = 8'hFF;

    localparam logic KIND_STANDARD = 1'b0;
    localparam logic KIND_SECURITY = 1'b1;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_START_REPEAT_MIN = 3'd0,
        REG_START_FULL_MIN   = 3'd1,
        REG_START_MAX        = 3'd2,
        REG_ONE_MIN          = 3'd3,
        REG_ONE_MAX          = 3'd4,
        REG_ZERO_MIN         = 3'd5,
        REG_ZERO_MAX         = 3'd6
    } reg_index_t;

    typedef struct packed {
        logic [CFG_DATA_W-1:0] start_repeat_min;
        logic [CFG_DATA_W-1:0] start_full_min;
        logic [CFG_DATA_W-1:0] start_max;
        logic [CFG_DATA_W-1:0] one_min;
        logic [CFG_DATA_W-1:0] one_max;
        logic [CFG_DATA_W-1:0] zero_min;
        logic [CFG_DATA_W-1:0] zero_max;
    } cfg_t;

    typedef struct packed {
        logic              code_kind;
        logic [BYTE_W-1:0] byte_three;
        logic [BYTE_W-1:0] byte_two;
        logic [BYTE_W-1:0] byte_one;
        logic [BYTE_W-1:0] byte_zero;
    } result_t;

    function automatic logic [BYTE_W-1:0] flip8(input logic [BYTE_W-1:0] v);
        logic [BYTE_W-1:0] r;
        for (int i = 0; i < BYTE_W; i++) begin
            r[i] = v[BYTE_W-1-i];
        end
        return r;
    endfunction

endpackage

@@ src/xrfpd_cfg_regs.sv @@
// Configuration register file for the pulse decoder: seven 16-bit timing-window bounds.
// Depends on xrfpd_pkg.
`timescale 1ns / 1ps

module xrfpd_cfg_regs (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [xrfpd_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [xrfpd_pkg::CFG_DATA_W-1:0]   cfg_data,
    output xrfpd_pkg::cfg_t                    cfg
);
    import xrfpd_pkg::*;

    cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg      = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_START_REPEAT_MIN: cfg_reg.start_repeat_min <= cfg_data;
                REG_START_FULL_MIN:   cfg_reg.start_full_min   <= cfg_data;
                REG_START_MAX:        cfg_reg.start_max        <= cfg_data;
                REG_ONE_MIN:          cfg_reg.one_min          <= cfg_data;
                REG_ONE_MAX:          cfg_reg.one_max          <= cfg_data;
                REG_ZERO_MIN:         cfg_reg.zero_min         <= cfg_data;
                REG_ZERO_MAX:         cfg_reg.zero_max         <= cfg_data;
                default: begin
                    // unmapped index: write ignored
                end
            endcase
        end
    end

endmodule

@@ src/xrfpd_frame_core.sv @@
// Input register, frame state (shift buffer and bit position) and single-pass
// window decode / frame classification. Depends on xrfpd_pkg.
`timescale 1ns / 1ps

module xrfpd_frame_core #(
    parameter int FRAME_BITS = xrfpd_pkg::FRAME_BITS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [xrfpd_pkg::INTERVAL_W-1:0]   s_tdata,
    input  xrfpd_pkg::cfg_t                    cfg,
    input  logic                               out_ready,
    output logic                               emit,
    output xrfpd_pkg::result_t                 result
);
    import xrfpd_pkg::*;

    logic                  in_valid_reg, in_valid_next;
    logic [INTERVAL_W-1:0] in_data_reg;
    logic [BUF_W-1:0]      buf_reg, buf_next;
    logic [POS_W-1:0]      pos_reg, pos_next;

    logic                  advance;
    logic                  start_hit, full_hit, one_hit, zero_hit;
    logic [IDX_W-1:0]      bit_idx;
    logic [BUF_W-1:0]      buf_set;
    logic [BYTE_W-1:0]     b0, b1, b2, b3;
    logic                  is_standard, is_security;

    assign advance  = in_valid_reg && out_ready;
    assign s_tready = !in_valid_reg || advance;

    assign start_hit = (in_data_reg >= cfg.start_repeat_min) && (in_data_reg <= cfg.start_max);
    assign full_hit  = in_data_reg >= cfg.start_full_min;
    assign one_hit   = (in_data_reg >= cfg.one_min) && (in_data_reg <= cfg.one_max);
    assign zero_hit  = (in_data_reg >= cfg.zero_min) && (in_data_reg <= cfg.zero_max);

    // bit positions are 1-based, LSB first
    assign bit_idx = IDX_W'(pos_reg - POS_W'(1));
    assign buf_set = one_hit ? (buf_reg | (BUF_W'(1) << bit_idx)) : buf_reg;

    assign b0 = flip8(buf_set[0*BYTE_W +: BYTE_W]);
    assign b1 = flip8(buf_set[1*BYTE_W +: BYTE_W]);
    assign b2 = flip8(buf_set[2*BYTE_W +: BYTE_W]);
    assign b3 = flip8(buf_set[3*BYTE_W +: BYTE_W]);

    assign is_standard = ((b1 & b0) == '0) && ((b3 & b2) == '0);
    assign is_security = ((b1 ^ b0) == SEC_LOW_XOR) && ((b3 ^ b2) == SEC_HIGH_XOR);

    always_comb begin
        result.code_kind  = is_standard ? KIND_STANDARD : KIND_SECURITY;
        result.byte_zero  = b0;
        result.byte_one   = b1;
        result.byte_two   = b2;
        result.byte_three = b3;
    end

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_tvalid && s_tready) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
    end

    always_comb begin
        buf_next = buf_reg;
        pos_next = pos_reg;
        emit     = 1'b0;
        if (advance) begin
            if (start_hit) begin
                // a weak start clears the buffer but leaves the position alone
                buf_next = '0;
                if (full_hit) begin
                    pos_next = POS_W'(1);
                end
            end else if (pos_reg == '0) begin
                // idle: ignore
            end else if (pos_reg > POS_W'(BUF_W)) begin
                pos_next = '0;
            end else if (!one_hit && !zero_hit) begin
                pos_next = '0;
            end else if (pos_reg < POS_W'(FRAME_BITS)) begin
                buf_next = buf_set;
                pos_next = pos_reg + POS_W'(1);
            end else begin
                buf_next = buf_set;
                pos_next = '0;
                emit     = is_standard || is_security;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            buf_reg      <= '0;
            pos_reg      <= '0;
        end else begin
            in_valid_reg <= in_valid_next;
            buf_reg      <= buf_next;
            pos_reg      <= pos_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_data_reg <= s_tdata;
        end
    end

    a_pos_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg <= POS_W'(FRAME_BITS))
        else $error("bit position beyond frame length");

    a_emit_goes_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        emit |-> (pos_next == '0))
        else $error("result emitted without returning to idle");

    a_full_start_arms: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && start_hit && full_hit) |=> (pos_reg == POS_W'(1) && buf_reg == '0))
        else $error("full start burst did not arm a fresh frame");

    a_emit_needs_item: assert property (@(posedge aclk) disable iff (!aresetn)
        emit |-> (in_valid_reg && out_ready))
        else $error("result produced without an item in the input register");

endmodule

@@ src/xrfpd_out_reg.sv @@
// Result register driving the master stream; takes a new result whenever it is
// empty or being drained. Depends on xrfpd_pkg.
`timescale 1ns / 1ps

module xrfpd_out_reg (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               load,
    input  xrfpd_pkg::result_t                 load_data,
    output logic                               can_load,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [xrfpd_pkg::OUT_DATA_W-1:0]   m_tdata,
    output logic                               m_tuser
);
    import xrfpd_pkg::*;

    logic    out_valid_reg;
    result_t out_data_reg;

    assign can_load = !out_valid_reg || m_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_data_reg.byte_three, out_data_reg.byte_two,
                       out_data_reg.byte_one, out_data_reg.byte_zero};
    assign m_tuser  = out_data_reg.code_kind;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (load) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            out_data_reg <= load_data;
        end
    end

endmodule

@@ src/x10_rf_pulse_decoder_unit.sv @@
// X10 RF pulse-distance decoder, 32-bit frames: one edge interval per transfer in,
// one classified frame per transfer out. An interval passes the input register and the
// decode into the output register (m_tvalid); one interval per clock, set by the single
// decode stage, unless back-pressure on m_ stalls the input register and s_tready.
// Synchronous active-low reset clears the windows, the frame state and both valid flags.
// Depends on xrfpd_pkg, xrfpd_cfg_regs, xrfpd_frame_core, xrfpd_out_reg.
`timescale 1ns / 1ps

module x10_rf_pulse_decoder_unit #(
    parameter int FRAME_BITS = xrfpd_pkg::FRAME_BITS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // s_tdata: [15:0] interval_us
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [xrfpd_pkg::INTERVAL_W-1:0]   s_tdata,
    // m_tdata: [7:0] byte_zero, [15:8] byte_one, [23:16] byte_two, [31:24] byte_three
    // m_tuser: [0] code_kind
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [xrfpd_pkg::OUT_DATA_W-1:0]   m_tdata,
    output logic                               m_tuser,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [xrfpd_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [xrfpd_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import xrfpd_pkg::*;

    cfg_t    cfg;
    result_t result;
    logic    emit;
    logic    can_load;

    xrfpd_cfg_regs u_cfg_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    xrfpd_frame_core #(
        .FRAME_BITS (FRAME_BITS)
    ) u_frame_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .cfg       (cfg),
        .out_ready (can_load),
        .emit      (emit),
        .result    (result)
    );

    xrfpd_out_reg u_out_reg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (emit),
        .load_data (result),
        .can_load  (can_load),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule
